[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the averager RTL. They compile to
// nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

[hw/rtl/mba_pkg.sv]
// ---------------------------------------------------------------------------
// Block averager package
// Field widths, default sizes and the word types of the averager.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mba_pkg;

	localparam int CHANNELS_DEF    = 18;
	localparam int BLOCK_LOG2_DEF  = 5;
	localparam int SAMPLE_BITS_DEF = 12;

	localparam int CHAN_W   = 5;
	localparam int SAMPLE_W = 12;
	localparam int AVG_W    = 12;
	// Channel counts run up to 32, so they need one bit more than an index.
	localparam int CH_CNT_W = CHAN_W + 1;

	localparam logic [CHAN_W-1:0] CHANNELS_USED_RST = CHAN_W'(18);

	typedef struct packed {
		logic [CHAN_W-1:0]   channel;
		logic [SAMPLE_W-1:0] sample;
	} in_word_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_channel;
		logic [AVG_W-1:0]  average;
	} out_word_t;

	typedef struct packed {
		logic      emit;
		out_word_t word;
	} mba_step_t;

endpackage

`default_nettype wire

[hw/rtl/multichannel_block_averager_top.sv]
// ---------------------------------------------------------------------------
// Multichannel block averager
// Per-channel boxcar average over a block of 2^BLOCK_LOG2 scan frames.
// ---------------------------------------------------------------------------
// Each input word carries one converter sample and its scan position. The
// sample is added to that channel's accumulator; a scan frame ends on the
// sample of the last channel in use, and every 2^BLOCK_LOG2 frames form a
// block. During the final frame of a block each channel's sample completes
// its sum, the block sends that sum shifted right by BLOCK_LOG2 as the
// channel's average and clears the accumulator. Samples on a channel at or
// beyond the channel count are dropped without effect. One word is taken
// per clock unless input ready drops: the word sits in the input register,
// where the add, shift and accumulator write happen, and the result then
// moves into the output register, which holds it until it is taken.
// The rate is set by that single read-modify-write of the accumulator bank;
// input ready only drops while a result is held in the output register and a
// new result is waiting behind it. channels_used is written through
// cfg_we/cfg_wdata, resets to 18, reads zero as one and caps at CHANNELS,
// and is to be changed only while no words are in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module multichannel_block_averager_top import mba_pkg::*; #(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int BLOCK_LOG2  = BLOCK_LOG2_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_word_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_word_t         out_data,
	input  logic              cfg_we,
	input  logic [CHAN_W-1:0] cfg_wdata
);

	logic              valid_s1;
	in_word_t          word_s1;
	logic [CHAN_W-1:0] channels_used_q;
	mba_step_t         step;
	logic              out_can_take;
	logic              advance;

	// The input stage moves on when its word yields no result or the output
	// register has room; an ignored or non-final-frame sample never waits.
	assign advance  = valid_s1 && (!step.emit || out_can_take);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channels_used_q <= CHANNELS_USED_RST;
		end else if (cfg_we) begin
			channels_used_q <= cfg_wdata;
		end
	end

	mba_accum #(
		.CHANNELS    (CHANNELS),
		.BLOCK_LOG2  (BLOCK_LOG2),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (advance),
		.word          (word_s1),
		.channels_used (channels_used_q),
		.step          (step)
	);

	mba_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && step.emit),
		.load_word (step.word),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.can_take  (out_can_take)
	);

	`ASSERT_PROP(a_stall_only_on_result, clk, arst_n, (valid_s1 && !advance) |-> (step.emit && out_valid && !out_ready), "input stage stalled without a blocked result")

endmodule

`default_nettype wire

[hw/rtl/mba_accum.sv]
// ---------------------------------------------------------------------------
// Block averager accumulator bank
// Per-channel sums, frame counter and the combinational add and shift.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mba_accum import mba_pkg::*; #(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int BLOCK_LOG2  = BLOCK_LOG2_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  in_word_t          word,
	input  logic [CHAN_W-1:0] channels_used,
	output mba_step_t         step
);

	localparam int SUM_W = SAMPLE_BITS + BLOCK_LOG2;
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [SUM_W-1:0]                sums_q [CHANNELS];
	logic [BLOCK_LOG2-1:0]           frame_count_q;
	logic [CH_CNT_W-1:0]             n_eff;
	logic [CH_CNT_W-1:0]             ch_ext;
	logic                            hit;
	logic                            last_chan;
	logic                            last_frame;
	logic [IDX_W-1:0]                idx;
	logic [SUM_W-1:0]                acc_old;
	logic [SAMPLE_BITS+SAMPLE_W-1:0] smp_wide;
	logic [SAMPLE_BITS-1:0]          smp;
	logic [SUM_W-1:0]                sum;
	logic [SUM_W+AVG_W-1:0]          sum_shifted;

	// A register value of zero acts as one channel, any value above the bank as all.
	always_comb begin
		priority if (channels_used == '0) begin
			n_eff = CH_CNT_W'(1);
		end else if (CH_CNT_W'(channels_used) > CH_CNT_W'(CHANNELS)) begin
			n_eff = CH_CNT_W'(CHANNELS);
		end else begin
			n_eff = CH_CNT_W'(channels_used);
		end
	end

	assign ch_ext     = CH_CNT_W'(word.channel);
	assign hit        = ch_ext < n_eff;
	assign last_chan  = ch_ext == (n_eff - CH_CNT_W'(1));
	assign last_frame = &frame_count_q;
	assign idx        = word.channel[IDX_W-1:0];
	assign acc_old    = hit ? sums_q[idx] : '0;

	assign smp_wide    = {SAMPLE_BITS'(0), word.sample};
	assign smp         = smp_wide[SAMPLE_BITS-1:0];
	assign sum         = acc_old + SUM_W'(smp);
	assign sum_shifted = {AVG_W'(0), sum} >> BLOCK_LOG2;

	assign step.emit             = hit && last_frame;
	assign step.word.out_channel = word.channel;
	assign step.word.average     = sum_shifted[AVG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sums_q[i] <= '0;
			end
		end else if (fire && hit) begin
			sums_q[idx] <= last_frame ? '0 : sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
		end else if (fire && hit && last_chan) begin
			frame_count_q <= frame_count_q + BLOCK_LOG2'(1);
		end
	end

	`ASSERT_PROP(a_emit_clears_sum, clk, arst_n, (fire && step.emit) |=> (sums_q[$past(idx)] == '0), "accumulator not cleared after its average was sent")
	`ASSERT_PROP(a_frame_holds, clk, arst_n, !fire |=> $stable(frame_count_q), "frame counter moved without an accepted sample")

endmodule

`default_nettype wire

[hw/rtl/mba_out_stage.sv]
// ---------------------------------------------------------------------------
// Block averager output register
// Holds one result word until the downstream side takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mba_out_stage import mba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_word_t load_word,
	input  logic      out_ready,
	output logic      out_valid,
	output out_word_t out_data,
	output logic      can_take
);

	logic      valid_q;
	out_word_t data_q;

	// The register frees up in the same cycle its word is taken.
	assign can_take  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_word;
		end
	end

	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, valid_q && !out_ready && load, "held result word overwritten")

endmodule

`default_nettype wire

[tb/sv/multichannel_block_averager_top_tb.sv]
// ---------------------------------------------------------------------------
// Multichannel block averager testbench
// Sends tagged converter samples into the averager and checks every block
// average it returns against a predictor in the testbench or a typed result.
// ---------------------------------------------------------------------------
// A short table of directed words comes first. It covers the reset channel
// count, an over-range count and a zero count, channels out of use, a frame
// that ends with earlier channels missing, a count changed in the middle of a
// block, and the smallest average. One row carries its result typed in.
// Random phases follow, each with its own channel count. Most words form
// well-ordered scan frames with random, all-zero or full-scale content. Some
// frames skip channels, and stray words land anywhere in the channel range.
// Both sides stall at random, apart from one stretch without stalls. Early
// on, the receiver also holds off for a long stretch so that the block backs
// up and stalls its input.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_block_averager_top_tb;
	import mba_pkg::*;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 7;
	localparam int N_CH          = CHANNELS_DEF;
	localparam int BLK_LOG2      = BLOCK_LOG2_DEF;
	localparam int SUM_W         = SAMPLE_BITS_DEF + BLOCK_LOG2_DEF;
	// Words taken by the design in all, ignored words included.
	localparam int WORDS_WANTED  = 1350;
	localparam int IDLE_PCT      = 10;
	localparam int NOISE_PCT     = 8;
	localparam int SKIP_PCT      = 5;
	// A dropped word yields no average, so after the last pending one the drain
	// wait lets any such word still in flight leave the pipeline.
	localparam int DRAIN_CYCLES  = 6;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_FROM    = 600;
	localparam int QUIET_TO      = 900;
	localparam int LIMIT_CYCLES  = 200000;
	localparam int DIR_ROWS      = 14;

	typedef enum logic [0:0] {OP_SAMPLE, OP_SET_CHANNELS} row_op_e;
	typedef enum logic [1:0] {EXP_NONE, EXP_TYPED, EXP_PREDICT} exp_kind_e;
	typedef enum int {CONTENT_RANDOM, CONTENT_FULL_SCALE, CONTENT_ZERO} content_e;

	// On OP_SET_CHANNELS rows, the channel field carries the new channel count.
	typedef struct packed {
		row_op_e             op;
		logic [CHAN_W-1:0]   channel;
		logic [SAMPLE_W-1:0] sample;
		int                  reps;
		exp_kind_e           kind;
		out_word_t           result;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	in_word_t          in_data;
	logic              out_valid;
	logic              out_ready;
	out_word_t         out_data;
	logic              cfg_we;
	logic [CHAN_W-1:0] cfg_wdata;

	// Predictor state. It holds the channel count register, one accumulator
	// per channel and the frame position within the current block.
	logic [CHAN_W-1:0]   chan_count_reg = CHANNELS_USED_RST;
	logic [SUM_W-1:0]    chan_sum [N_CH];
	logic [BLK_LOG2-1:0] frame_idx = '0;

	out_word_t averages_due [$];
	int        words_taken        = 0;
	int        mismatch_count     = 0;
	int        cycle_count        = 0;
	logic      squeeze_req;

	dir_row_t  directed_rows [DIR_ROWS];

	multichannel_block_averager_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// Zero and over-range counts are clamped, so a count of zero acts as one
	// channel and anything above the channel bank acts as the full bank.
	function automatic int active_channels();
		int n;
		n = int'(chan_count_reg);
		if (n == 0) begin
			n = 1;
		end
		if (n > N_CH) begin
			n = N_CH;
		end
		return n;
	endfunction

	// Steps the predictor by one sample. The return value is 1 when the word
	// completes a block sum for its channel and so produces an average.
	function automatic bit average_predict(input in_word_t w, output out_word_t avg);
		int               n;
		logic [SUM_W-1:0] sum;
		bit               emits;
		n = active_channels();
		avg = '0;
		// Words on a channel out of use leave every piece of state alone.
		if (int'(w.channel) >= n) begin
			return 1'b0;
		end
		// The accumulator wraps at its own width, which only matters when a
		// channel collects more than a block's worth of samples.
		sum = chan_sum[w.channel] + SUM_W'(w.sample);
		emits = (frame_idx == '1);
		if (emits) begin
			avg.out_channel = w.channel;
			avg.average = AVG_W'(sum >> BLK_LOG2);
			chan_sum[w.channel] = '0;
		end else begin
			chan_sum[w.channel] = sum;
		end
		// The last channel in use ends the frame, even if earlier channels
		// of the frame never showed up.
		if (int'(w.channel) == n - 1) begin
			frame_idx = frame_idx + 1'b1;
		end
		return emits;
	endfunction

	function automatic bit quiet_stretch();
		return words_taken >= QUIET_FROM && words_taken < QUIET_TO;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 50) begin
			$display("MISMATCH @%0t: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	task automatic check_average(input out_word_t got);
		out_word_t want;
		if (averages_due.size() == 0) begin
			report_mismatch($sformatf("average with none pending: ch %0d avg %0d",
				got.out_channel, got.average));
			return;
		end
		want = averages_due.pop_front();
		if (got.out_channel !== want.out_channel) begin
			report_mismatch($sformatf("out_channel %0d, predicted %0d",
				got.out_channel, want.out_channel));
		end
		if (got.average !== want.average) begin
			report_mismatch($sformatf("average %0d on ch %0d, predicted %0d",
				got.average, want.out_channel, want.average));
		end
	endtask

	// Offers one word and returns at the edge where it is taken. Random idle
	// cycles come before the word, never between its valid and its handshake.
	task automatic push_sample(input in_word_t w, input exp_kind_e kind,
			input out_word_t typed);
		out_word_t predicted;
		bit        emits;
		while (!quiet_stretch() && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		words_taken++;
		// The predictor always runs so its state keeps pace. Typed rows use
		// their own result instead of the predicted one.
		emits = average_predict(w, predicted);
		if (kind == EXP_TYPED) begin
			averages_due.push_back(typed);
		end else if (kind == EXP_PREDICT && emits) begin
			averages_due.push_back(predicted);
		end
	endtask

	// Waits until every pending average has arrived, then lets the pipeline
	// run dry, since a dropped word produces no average to wait for.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (averages_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_channels(input logic [CHAN_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		chan_count_reg = value;
	endtask

	// Receiver: checks each accepted average and drives out_ready for the
	// next cycle. The long hold-off is counted here, once the stimulus asks.
	initial begin
		int hold_left;
		bit squeezed;
		hold_left = 0;
		squeezed = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				check_average(out_data);
			end
			if (squeeze_req && !squeezed) begin
				squeezed = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet_stretch() || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	// The run stops here if the design stops answering.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [CHAN_W-1:0]   setting;
		logic [SAMPLE_W-1:0] smp;
		in_word_t            w;
		content_e            content;
		int                  n;
		int                  frames;
		int                  pick;
		bit                  clean;

		foreach (chan_sum[i]) begin
			chan_sum[i] = '0;
		end
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		squeeze_req = 1'b0;

		// The first rows run with the reset count of 18 channels. The frame
		// counter reaches the last frame of its block only after a long run
		// of one-channel frames. That run ends on a sum of 31, which the
		// shift truncates to zero.
		directed_rows = '{
			'{OP_SAMPLE,       5'd5,  12'd4095, 1,  EXP_NONE,    '0},
			'{OP_SAMPLE,       5'd17, 12'd0,    1,  EXP_NONE,    '0},
			'{OP_SAMPLE,       5'd18, 12'd4095, 1,  EXP_NONE,    '0},
			'{OP_SAMPLE,       5'd31, 12'd4095, 1,  EXP_NONE,    '0},
			'{OP_SET_CHANNELS, 5'd31, 12'd0,    0,  EXP_NONE,    '0},
			'{OP_SAMPLE,       5'd18, 12'd1,    1,  EXP_NONE,    '0},
			'{OP_SAMPLE,       5'd17, 12'd2048, 1,  EXP_PREDICT, '0},
			'{OP_SET_CHANNELS, 5'd0,  12'd0,    0,  EXP_NONE,    '0},
			'{OP_SAMPLE,       5'd1,  12'd4095, 1,  EXP_NONE,    '0},
			'{OP_SAMPLE,       5'd0,  12'd0,    29, EXP_PREDICT, '0},
			'{OP_SAMPLE,       5'd0,  12'd31,   1,  EXP_TYPED,   '0},
			'{OP_SET_CHANNELS, 5'd18, 12'd0,    0,  EXP_NONE,    '0},
			'{OP_SAMPLE,       5'd17, 12'd4095, 1,  EXP_PREDICT, '0},
			'{OP_SAMPLE,       5'd0,  12'd4095, 1,  EXP_PREDICT, '0}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].op == OP_SET_CHANNELS) begin
				set_channels(directed_rows[i].channel);
			end else begin
				for (int k = 0; k < directed_rows[i].reps; k++) begin
					w.channel = directed_rows[i].channel;
					w.sample = directed_rows[i].sample;
					push_sample(w, directed_rows[i].kind, directed_rows[i].result);
				end
			end
		end

		// Random phases. The first phase uses a single channel, so averages
		// come often enough for the long receiver hold-off to fill the block.
		for (int phase = 0; words_taken < WORDS_WANTED; phase++) begin
			pick = $urandom_range(9);
			case (pick)
				0: begin
					setting = '0;
				end
				1: begin
					setting = '1;
				end
				2: begin
					setting = CHAN_W'(N_CH);
				end
				3: begin
					setting = CHAN_W'($urandom_range(30, N_CH + 1));
				end
				4, 5, 6: begin
					setting = CHAN_W'($urandom_range(4, 1));
				end
				default: begin
					setting = CHAN_W'($urandom_range(N_CH - 1, 1));
				end
			endcase
			if (phase == 0) begin
				setting = CHAN_W'(1);
			end
			set_channels(setting);
			n = active_channels();

			pick = $urandom_range(7);
			content = (pick == 0) ? CONTENT_FULL_SCALE
				: (pick == 1) ? CONTENT_ZERO : CONTENT_RANDOM;
			// Full-scale and all-zero phases stay clean, so that a whole
			// block can reach the top and bottom of the average range.
			clean = (content != CONTENT_RANDOM);
			frames = (n <= 4) ? $urandom_range(96, 40) : $urandom_range(40, 6);
			if (phase == 0) begin
				frames = 400;
				squeeze_req <= 1'b1;
			end

			for (int f = 0; f < frames && words_taken < WORDS_WANTED; f++) begin
				for (int c = 0; c < n; c++) begin
					if (!clean && $urandom_range(99) < NOISE_PCT) begin
						w.channel = CHAN_W'($urandom_range(31));
						w.sample = SAMPLE_W'($urandom_range(4095));
						push_sample(w, EXP_PREDICT, '0);
					end
					if (!clean && c != n - 1 && $urandom_range(99) < SKIP_PCT) begin
						continue;
					end
					case (content)
						CONTENT_FULL_SCALE: smp = '1;
						CONTENT_ZERO:       smp = '0;
						default:            smp = SAMPLE_W'($urandom_range(4095));
					endcase
					w.channel = CHAN_W'(c);
					w.sample = smp;
					push_sample(w, EXP_PREDICT, '0);
				end
			end
		end

		wait_idle();
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/mba_pkg.sv
hw/rtl/mba_accum.sv
hw/rtl/mba_out_stage.sv
hw/rtl/multichannel_block_averager_top.sv
tb/sv/multichannel_block_averager_top_tb.sv
